// ===== hdl/video_register_port_core_defines.svh =====
// ----------------------------------------------------------------------------
// Video register port assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VIDEO_REGISTER_PORT_CORE_DEFINES_SVH
`define VIDEO_REGISTER_PORT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define VRP_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error("video register port check failed");

// Next-cycle implication, disabled while reset is asserted
`define VRP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error("video register port check failed");

`else

`define VRP_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons)
`define VRP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== hdl/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Types and fixed constants of the video register port.
// ----------------------------------------------------------------------------
package vrp_pkg;

	// Item kinds on the input channel
	typedef enum logic [1:0] {
		KIND_READ     = 2'd0,
		KIND_WRITE    = 2'd1,
		KIND_VB_START = 2'd2,
		KIND_VB_END   = 2'd3
	} kind_t;

	// Register selects (cpu_address[2:0])
	typedef enum logic [2:0] {
		REG_CTRL1    = 3'd0,
		REG_CTRL2    = 3'd1,
		REG_STATUS   = 3'd2,
		REG_OAM_ADDR = 3'd3,
		REG_OAM_DATA = 3'd4,
		REG_SCROLL   = 3'd5,
		REG_VADDR    = 3'd6,
		REG_VDATA    = 3'd7
	} reg_sel_t;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	localparam int SPRITE_BYTES = 256;
	localparam int SPRITE_AW    = $clog2(SPRITE_BYTES);
	localparam int PAL_BYTES    = 32;
	localparam int PAL_AW       = $clog2(PAL_BYTES);

	// Video address decode
	localparam logic [13:0] VADDR_PAL_BASE = 14'h3F00;
	localparam int          STEP_BIT       = 2;
	localparam logic [15:0] STEP_ONE       = 16'd1;
	localparam logic [15:0] STEP_ROW       = 16'd32;
	localparam int          VBLANK_BIT     = 7;

endpackage

// ===== hdl/video_register_port_core.sv =====
// ----------------------------------------------------------------------------
// video_register_port_core
// CPU-side register port of a tile video processor: control, status, sprite
// memory, scroll, video address and the buffered data port into name and
// palette memory.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, kind, cpu_address,    | to block
//          | write_data                                |
//  out     | out_valid, out_ready, read_data           | from block
//
// Each item is accepted, then executed: the accept cycle issues the sprite and name
// memory reads, the execute cycle uses the registered read data and writes back.
// One item is in work at a time; the result sits in an output register, so
// the next item is taken while it waits. A stalled output holds the execute
// cycle until the output register frees up.
// After reset a clearing pass zeroes name memory, with in_ready low.
`include "video_register_port_core_defines.svh"

module video_register_port_core #(
	parameter int NAME_BYTES = 2048
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  vrp_pkg::kind_t kind,
	input  logic [15:0]    cpu_address,
	input  logic [7:0]     write_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     read_data
);
	import vrp_pkg::*;

	localparam int NAME_AW = $clog2(NAME_BYTES);

	// Control state
	state_t               state_q;
	logic [NAME_AW-1:0]   clr_q;
	logic [7:0]           ctrl1_q;
	logic [7:0]           ctrl2_q;
	logic [7:0]           status_q;
	logic [SPRITE_AW-1:0] sprite_ptr_q;
	logic [7:0]           scroll_q [2];
	logic                 toggle_q;
	logic [15:0]          video_ptr_q;
	logic [7:0]           rbuf_q;
	logic [7:0]           pal_q [PAL_BYTES];
	logic                 out_valid_q;
	logic [7:0]           out_data_q;

	// Captured item
	kind_t       kind_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	reg_sel_t    sel_s1;

	// Memories
	logic [7:0] name_mem [NAME_BYTES];
	logic [7:0] sprite_mem [SPRITE_BYTES];
	logic [7:0] name_rd_s1;
	logic [7:0] sprite_rd_s1;

	logic               in_fire;
	logic               do_exec;
	logic [13:0]        vaddr;
	logic               pal_area;
	logic               name_hit;
	logic [NAME_AW-1:0] name_idx;
	logic [PAL_AW-1:0]  pal_idx;
	logic               name_we;
	logic [NAME_AW-1:0] name_waddr;
	logic [7:0]         name_wdata;
	logic               sprite_we;
	logic [7:0]         result_d;
	logic [15:0]        step;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign do_exec   = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign read_data = out_data_q;
	assign sel_s1    = reg_sel_t'(addr_s1[2:0]);

	// Video address decode; the pointer only moves in the execute cycle
	assign vaddr    = video_ptr_q[13:0];
	assign pal_area = (vaddr >= VADDR_PAL_BASE);
	assign name_hit = !pal_area && vaddr[13]
		&& ({1'b0, vaddr[11:0]} < 13'(NAME_BYTES));
	assign name_idx = vaddr[NAME_AW-1:0];
	assign pal_idx  = vaddr[PAL_AW-1:0];
	assign step     = ctrl1_q[STEP_BIT] ? STEP_ROW : STEP_ONE;

	// Name memory write port: clearing pass or data-port write
	always_comb begin
		name_we    = 1'b0;
		name_waddr = clr_q;
		name_wdata = 8'd0;
		if (state_q == ST_CLEAR) begin
			name_we = 1'b1;
		end else if (do_exec && kind_s1 == KIND_WRITE && sel_s1 == REG_VDATA && name_hit) begin
			name_we    = 1'b1;
			name_waddr = name_idx;
			name_wdata = wdata_s1;
		end
	end

	assign sprite_we = do_exec && kind_s1 == KIND_WRITE && sel_s1 == REG_OAM_DATA;

	always_ff @(posedge clk) begin
		if (name_we) begin
			name_mem[name_waddr] <= name_wdata;
		end
		if (in_fire) begin
			name_rd_s1 <= name_mem[name_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (sprite_we) begin
			sprite_mem[sprite_ptr_q] <= wdata_s1;
		end
		if (in_fire) begin
			sprite_rd_s1 <= sprite_mem[sprite_ptr_q];
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1  <= kind;
			addr_s1  <= cpu_address;
			wdata_s1 <= write_data;
		end
	end

	// Result byte
	always_comb begin
		result_d = 8'd0;
		if (kind_s1 == KIND_READ) begin
			unique case (sel_s1)
				REG_VDATA:    result_d = pal_area ? pal_q[pal_idx] : rbuf_q;
				REG_OAM_DATA: result_d = sprite_rd_s1;
				REG_STATUS:   result_d = status_q;
				default:      result_d = addr_s1[15:8];
			endcase
		end
	end

	// Sequencer and register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			ctrl1_q      <= 8'd0;
			ctrl2_q      <= 8'd0;
			status_q     <= 8'd0;
			sprite_ptr_q <= '0;
			scroll_q[0]  <= 8'd0;
			scroll_q[1]  <= 8'd0;
			toggle_q     <= 1'b0;
			video_ptr_q  <= 16'd0;
			rbuf_q       <= 8'd0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < PAL_BYTES; i++) begin
				pal_q[i] <= 8'd0;
			end
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NAME_AW'(NAME_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (do_exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Output register
			if (do_exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (do_exec) begin
				unique case (kind_s1)
					KIND_READ: begin
						unique case (sel_s1)
							REG_VDATA: begin
								if (pal_area) begin
									rbuf_q <= pal_q[pal_idx];
								end else begin
									rbuf_q <= name_hit ? name_rd_s1 : 8'd0;
								end
								video_ptr_q <= video_ptr_q + step;
							end
							REG_OAM_DATA: sprite_ptr_q <= sprite_ptr_q + 1'b1;
							REG_STATUS:   status_q[VBLANK_BIT] <= 1'b0;
							default: ;
						endcase
					end
					KIND_WRITE: begin
						unique case (sel_s1)
							REG_CTRL1:    ctrl1_q <= wdata_s1;
							REG_CTRL2:    ctrl2_q <= wdata_s1;
							REG_OAM_ADDR: sprite_ptr_q <= wdata_s1;
							REG_OAM_DATA: sprite_ptr_q <= sprite_ptr_q + 1'b1;
							REG_SCROLL: begin
								scroll_q[toggle_q] <= wdata_s1;
								toggle_q           <= !toggle_q;
							end
							REG_VADDR: begin
								if (toggle_q) begin
									video_ptr_q[7:0] <= wdata_s1;
								end else begin
									video_ptr_q[15:8] <= wdata_s1;
								end
								toggle_q <= !toggle_q;
							end
							REG_VDATA: begin
								// palette: entries at multiples of four mirror
								if (pal_area) begin
									if (vaddr[1:0] == 2'd0) begin
										pal_q[{1'b0, vaddr[3:0]}] <= wdata_s1;
										pal_q[{1'b1, vaddr[3:0]}] <= wdata_s1;
									end else begin
										pal_q[pal_idx] <= wdata_s1;
									end
								end
								video_ptr_q <= video_ptr_q + step;
							end
							default: ;
						endcase
					end
					KIND_VB_START: status_q[VBLANK_BIT] <= 1'b1;
					KIND_VB_END:   status_q[VBLANK_BIT] <= 1'b0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_exec) begin
			out_data_q <= result_d;
		end
	end

	// Checks
	`VRP_ASSERT_NEXT(a_accept_exec, clk, arst_n, in_fire, state_q == ST_EXEC)
	`VRP_ASSERT_NEXT(a_stall_holds, clk, arst_n,
		(state_q == ST_EXEC) && out_valid_q && !out_ready, state_q == ST_EXEC)
	`VRP_ASSERT_NEXT(a_ptr_quiet, clk, arst_n, state_q != ST_EXEC, $stable(video_ptr_q))
	`VRP_ASSERT_NEXT(a_clear_done, clk, arst_n,
		(state_q == ST_CLEAR) && (clr_q == NAME_AW'(NAME_BYTES - 1)), state_q == ST_IDLE)
	`VRP_ASSERT_SAME(a_exec_frees_out, clk, arst_n, do_exec, !out_valid_q || out_ready)

endmodule
